FILE: hw/rtl/dwa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwa_pkg
// Shared types, constants and the fold function of the deque aggregator.
// ----------------------------------------------------------------------------
package dwa_pkg;

   localparam int CAPACITY   = 64;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int ADDR_W     = IDX_W + 2;

   // memory regions
   localparam logic [1:0] RGN_FRONT = 2'd0;
   localparam logic [1:0] RGN_BACK  = 2'd1;
   localparam logic [1:0] RGN_SCR   = 2'd2;

   // commands
   localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
   localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [2:0] CMD_POP_BACK   = 3'd3;
   localparam logic [2:0] CMD_QUERY      = 3'd4;

   // fold operations
   localparam logic [2:0] OP_SUM = 3'd0;
   localparam logic [2:0] OP_MIN = 3'd1;
   localparam logic [2:0] OP_MAX = 3'd2;
   localparam logic [2:0] OP_AND = 3'd3;
   localparam logic [2:0] OP_OR  = 3'd4;
   localparam logic [2:0] OP_XOR = 3'd5;

   // status codes
   localparam logic [1:0] STS_OK    = 2'd0;
   localparam logic [1:0] STS_EMPTY = 2'd1;
   localparam logic [1:0] STS_FULL  = 2'd2;

   typedef struct packed {
      logic [2:0]            command;
      logic [DATA_WIDTH-1:0] value;
   } req_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] front_value;
      logic [DATA_WIDTH-1:0] back_value;
      logic [DATA_WIDTH-1:0] aggregate;
      logic [CNT_W-1:0]      count;
      logic [1:0]            status;
   } rsp_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] value;
      logic [DATA_WIDTH-1:0] prefix;
   } entry_type;

   function automatic logic [DATA_WIDTH-1:0] fold(input logic [2:0] op,
                                                  input logic [DATA_WIDTH-1:0] a,
                                                  input logic [DATA_WIDTH-1:0] b);
      logic [DATA_WIDTH-1:0] r;
      unique case (op)
         OP_MIN:  r = (a < b) ? a : b;
         OP_MAX:  r = (a > b) ? a : b;
         OP_AND:  r = a & b;
         OP_OR:   r = a | b;
         OP_XOR:  r = a ^ b;
         default: r = a + b;
      endcase
      return r;
   endfunction

endpackage

FILE: hw/rtl/dwa_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwa_store
// Entry memory: front stack, back stack and scratch regions, one write and
// one registered read per cycle.
// ----------------------------------------------------------------------------
module dwa_store (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [dwa_pkg::ADDR_W-1:0]  wr_addr,
   input  dwa_pkg::entry_type          wr_data,
   input  logic [dwa_pkg::ADDR_W-1:0]  rd_addr,
   output dwa_pkg::entry_type          rd_data
);

   dwa_pkg::entry_type mem [0:(1 << dwa_pkg::ADDR_W)-1];
   dwa_pkg::entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/deque_window_aggregator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_window_aggregator
// Two-stack deque with a running fold; stacks and rebuild scratch live in
// one synchronous memory, tops are cached in registers.
//
//  channel   ports                        transfer
//  request   start, busy, req_data        start && !busy
//  result    rsp_valid, rsp_data          one-cycle strobe
//  csr       csr_valid, csr_ready, data   valid && ready
//
//  A transaction keeps busy high through the execute, two top-read and
//  result states; the result strobes in the same cycle that busy falls.
//  A rebalance walks all n entries twice through the single read port
//  (gather, then rebuild of both halves) before the top reads.
//  Synchronous active-high reset empties the queue and sets op to sum.
//  The result cannot be stalled.
// ----------------------------------------------------------------------------
module deque_window_aggregator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  dwa_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   output dwa_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [2:0]                          csr_data
);

   localparam int CW = dwa_pkg::CNT_W;
   localparam int IW = dwa_pkg::IDX_W;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_EXEC  = 8'b0000_0010,
      ST_COPY  = 8'b0000_0100,
      ST_FRONT = 8'b0000_1000,
      ST_BACK  = 8'b0001_0000,
      ST_REF_F = 8'b0010_0000,
      ST_REF_B = 8'b0100_0000,
      ST_REF_D = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [2:0] cmd_ff, cmd_in;
   logic [dwa_pkg::DATA_WIDTH-1:0] val_ff, val_in;
   logic [1:0] status_ff, status_in;
   logic [CW-1:0] fd_ff, fd_in, bd_ff, bd_in;
   dwa_pkg::entry_type fc_ff, fc_in, bc_ff, bc_in;
   logic [2:0] op_ff;
   logic [CW-1:0] i_ff, i_in, pi_ff, pi_in;
   logic pv_ff, pv_in;
   logic [dwa_pkg::DATA_WIDTH-1:0] run_ff, run_in;
   dwa_pkg::rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic wr_en;
   logic [dwa_pkg::ADDR_W-1:0] wr_addr, rd_addr;
   dwa_pkg::entry_type wr_data, rd_data;

   logic [CW-1:0] n_tot, half, tmp;
   logic [CW+1:0] lo3, hi_x;
   logic [CW-1:0] nfd, nbd, lo, hi;
   logic chg;
   logic [dwa_pkg::DATA_WIDTH-1:0] pfx;
   logic fdn, bdn;

   dwa_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign n_tot     = fd_ff + bd_ff;
   assign half      = n_tot >> 1;

   // sequencer and datapath
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      val_in       = val_ff;
      status_in    = status_ff;
      fd_in        = fd_ff;
      bd_in        = bd_ff;
      fc_in        = fc_ff;
      bc_in        = bc_ff;
      i_in         = i_ff;
      pi_in        = pi_ff;
      pv_in        = 1'b0;
      run_in       = run_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      rd_addr      = '0;
      nfd          = fd_ff;
      nbd          = bd_ff;
      chg          = 1'b0;
      lo           = '0;
      hi           = '0;
      lo3          = '0;
      hi_x         = '0;
      tmp          = '0;
      pfx          = '0;
      fdn          = (fd_ff != '0);
      bdn          = (bd_ff != '0);
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in   = req_data.command;
               val_in   = req_data.value;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            status_in = dwa_pkg::STS_OK;
            if (cmd_ff == dwa_pkg::CMD_PUSH_FRONT || cmd_ff == dwa_pkg::CMD_PUSH_BACK) begin
               if (n_tot >= CW'(dwa_pkg::CAPACITY)) begin
                  status_in = dwa_pkg::STS_FULL;
               end else if (cmd_ff == dwa_pkg::CMD_PUSH_FRONT) begin
                  pfx     = fdn ? dwa_pkg::fold(op_ff, val_ff, fc_ff.prefix) : val_ff;
                  wr_en   = 1'b1;
                  wr_addr = {dwa_pkg::RGN_FRONT, fd_ff[IW-1:0]};
                  wr_data = '{value: val_ff, prefix: pfx};
                  nfd     = fd_ff + 1'b1;
                  chg     = 1'b1;
               end else begin
                  pfx     = bdn ? dwa_pkg::fold(op_ff, bc_ff.prefix, val_ff) : val_ff;
                  wr_en   = 1'b1;
                  wr_addr = {dwa_pkg::RGN_BACK, bd_ff[IW-1:0]};
                  wr_data = '{value: val_ff, prefix: pfx};
                  nbd     = bd_ff + 1'b1;
                  chg     = 1'b1;
               end
            end else if (cmd_ff == dwa_pkg::CMD_POP_FRONT || cmd_ff == dwa_pkg::CMD_POP_BACK) begin
               if (n_tot == '0) begin
                  status_in = dwa_pkg::STS_EMPTY;
               end else begin
                  chg = 1'b1;
                  if (cmd_ff == dwa_pkg::CMD_POP_FRONT) begin
                     if (fdn) nfd = fd_ff - 1'b1;
                     else     nbd = bd_ff - 1'b1;
                  end else begin
                     if (bdn) nbd = bd_ff - 1'b1;
                     else     nfd = fd_ff - 1'b1;
                  end
               end
            end
            fd_in = nfd;
            bd_in = nbd;
            // rebalance when one stack exceeds three times the other
            lo   = (nfd < nbd) ? nfd : nbd;
            hi   = (nfd < nbd) ? nbd : nfd;
            lo3  = ({2'b00, lo} << 1) + {2'b00, lo};
            hi_x = {2'b00, hi};
            i_in = '0;
            if (chg && (lo3 < hi_x)) state_in = ST_COPY;
            else                     state_in = ST_REF_F;
         end
         ST_COPY: begin
            // gather values front to back into scratch
            if (i_ff < n_tot) begin
               if (i_ff < fd_ff) begin
                  tmp     = fd_ff - 1'b1 - i_ff;
                  rd_addr = {dwa_pkg::RGN_FRONT, tmp[IW-1:0]};
               end else begin
                  tmp     = i_ff - fd_ff;
                  rd_addr = {dwa_pkg::RGN_BACK, tmp[IW-1:0]};
               end
               pv_in = 1'b1;
               pi_in = i_ff;
               i_in  = i_ff + 1'b1;
            end
            if (pv_ff) begin
               wr_en   = 1'b1;
               wr_addr = {dwa_pkg::RGN_SCR, pi_ff[IW-1:0]};
               wr_data = '{value: rd_data.value, prefix: '0};
            end
            if (i_ff == n_tot && !pv_ff) begin
               i_in     = '0;
               state_in = ST_FRONT;
            end
         end
         ST_FRONT: begin
            // rebuild front stack from the lower half, bottom up
            if (i_ff < half) begin
               tmp     = half - 1'b1 - i_ff;
               rd_addr = {dwa_pkg::RGN_SCR, tmp[IW-1:0]};
               pv_in   = 1'b1;
               pi_in   = i_ff;
               i_in    = i_ff + 1'b1;
            end
            if (pv_ff) begin
               pfx     = (pi_ff == '0) ? rd_data.value
                                       : dwa_pkg::fold(op_ff, rd_data.value, run_ff);
               wr_en   = 1'b1;
               wr_addr = {dwa_pkg::RGN_FRONT, pi_ff[IW-1:0]};
               wr_data = '{value: rd_data.value, prefix: pfx};
               run_in  = pfx;
            end
            if (i_ff == half && !pv_ff) begin
               i_in     = half;
               state_in = ST_BACK;
            end
         end
         ST_BACK: begin
            // rebuild back stack from the upper half
            if (i_ff < n_tot) begin
               rd_addr = {dwa_pkg::RGN_SCR, i_ff[IW-1:0]};
               pv_in   = 1'b1;
               pi_in   = i_ff;
               i_in    = i_ff + 1'b1;
            end
            if (pv_ff) begin
               tmp     = pi_ff - half;
               pfx     = (tmp == '0) ? rd_data.value
                                     : dwa_pkg::fold(op_ff, run_ff, rd_data.value);
               wr_en   = 1'b1;
               wr_addr = {dwa_pkg::RGN_BACK, tmp[IW-1:0]};
               wr_data = '{value: rd_data.value, prefix: pfx};
               run_in  = pfx;
            end
            if (i_ff == n_tot && !pv_ff) begin
               fd_in    = half;
               bd_in    = n_tot - half;
               state_in = ST_REF_F;
            end
         end
         ST_REF_F: begin
            tmp      = fd_ff - 1'b1;
            rd_addr  = {dwa_pkg::RGN_FRONT, tmp[IW-1:0]};
            state_in = ST_REF_B;
         end
         ST_REF_B: begin
            tmp      = bd_ff - 1'b1;
            rd_addr  = {dwa_pkg::RGN_BACK, tmp[IW-1:0]};
            fc_in    = rd_data;
            state_in = ST_REF_D;
         end
         ST_REF_D: begin
            // back top arrives; form the result
            bc_in = rd_data;
            rsp_in.front_value = fdn ? fc_ff.value : (bdn ? rd_data.value : '0);
            rsp_in.back_value  = bdn ? rd_data.value : (fdn ? fc_ff.value : '0);
            if (fdn && bdn)
               rsp_in.aggregate = dwa_pkg::fold(op_ff, fc_ff.prefix, rd_data.prefix);
            else if (fdn)
               rsp_in.aggregate = fc_ff.prefix;
            else if (bdn)
               rsp_in.aggregate = rd_data.prefix;
            else
               rsp_in.aggregate = '0;
            rsp_in.count  = n_tot;
            rsp_in.status = status_ff;
            rsp_valid_in  = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fd_ff        <= '0;
         bd_ff        <= '0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         op_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         fd_ff        <= fd_in;
         bd_ff        <= bd_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            op_ff <= csr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      val_ff    <= val_in;
      status_ff <= status_in;
      fc_ff     <= fc_in;
      bc_ff     <= bc_in;
      i_ff      <= i_in;
      pi_ff     <= pi_in;
      run_ff    <= run_in;
      rsp_ff    <= rsp_in;
   end

   // checks
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      (fd_ff + bd_ff) <= CW'(dwa_pkg::CAPACITY))
      else $error("stack depths exceed capacity");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == dwa_pkg::STS_FULL)
         |-> (rsp_data.count == CW'(dwa_pkg::CAPACITY)))
      else $error("full status with non-full count");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == dwa_pkg::STS_EMPTY) |-> (rsp_data.count == '0))
      else $error("empty status with non-empty count");

endmodule

FILE: tb/tb_deque_window_aggregator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_deque_window_aggregator
// Drives push/pop/query commands into the deque aggregator under every fold
// operation, mirrors the two-stack deque with its rebuild in a local model,
// and checks every result field against the model's prediction.
// ----------------------------------------------------------------------------
module tb_deque_window_aggregator;

   localparam int DW          = dwa_pkg::DATA_WIDTH;
   localparam int CAP         = dwa_pkg::CAPACITY;
   localparam int CYCLE_LIMIT = 2000000;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   dwa_pkg::req_type req_data;
   logic             rsp_valid;
   dwa_pkg::rsp_type rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   logic [2:0]       csr_data;

   deque_window_aggregator u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b0; #5;
      clock = 1'b1; #5;
   end

   // deque model state
   logic [2:0]    mdl_op;
   logic [DW-1:0] fr_val [CAP];
   logic [DW-1:0] fr_pre [CAP];
   logic [DW-1:0] bk_val [CAP];
   logic [DW-1:0] bk_pre [CAP];
   int            fr_depth;
   int            bk_depth;

   dwa_pkg::rsp_type expected_rsps [$];
   int               mismatches;
   int               cycle_count;
   int               idle_pct;

   function automatic logic [DW-1:0] combine(logic [DW-1:0] a, logic [DW-1:0] b);
      case (mdl_op)
         dwa_pkg::OP_MIN: return (a < b) ? a : b;
         dwa_pkg::OP_MAX: return (a > b) ? a : b;
         dwa_pkg::OP_AND: return a & b;
         dwa_pkg::OP_OR:  return a | b;
         dwa_pkg::OP_XOR: return a ^ b;
         default:         return a + b;
      endcase
   endfunction

   task automatic model_add_front(logic [DW-1:0] v);
      fr_pre[fr_depth] = (fr_depth != 0) ? combine(v, fr_pre[fr_depth-1]) : v;
      fr_val[fr_depth] = v;
      fr_depth++;
   endtask

   task automatic model_add_back(logic [DW-1:0] v);
      bk_pre[bk_depth] = (bk_depth != 0) ? combine(bk_pre[bk_depth-1], v) : v;
      bk_val[bk_depth] = v;
      bk_depth++;
   endtask

   // split in half and rebuild both stacks when one dwarfs the other
   task automatic model_rebalance();
      logic [DW-1:0] flat [CAP];
      int lo, hi, n, half;
      lo = (fr_depth < bk_depth) ? fr_depth : bk_depth;
      hi = (fr_depth < bk_depth) ? bk_depth : fr_depth;
      n  = fr_depth + bk_depth;
      if (!(3 * lo < hi)) return;
      for (int i = 0; i < n; i++)
         flat[i] = (i < fr_depth) ? fr_val[fr_depth-1-i] : bk_val[i-fr_depth];
      half = n / 2;
      fr_depth = 0;
      bk_depth = 0;
      for (int i = 0; i < half; i++) model_add_front(flat[half-1-i]);
      for (int i = half; i < n; i++) model_add_back(flat[i]);
   endtask

   task automatic predict_deque(dwa_pkg::req_type rq);
      dwa_pkg::rsp_type r;
      int n;
      r = '0;
      n = fr_depth + bk_depth;
      if (rq.command == dwa_pkg::CMD_PUSH_FRONT || rq.command == dwa_pkg::CMD_PUSH_BACK) begin
         if (n >= CAP) r.status = dwa_pkg::STS_FULL;
         else begin
            if (rq.command == dwa_pkg::CMD_PUSH_FRONT) model_add_front(rq.value);
            else model_add_back(rq.value);
            model_rebalance();
         end
      end else if (rq.command == dwa_pkg::CMD_POP_FRONT ||
                   rq.command == dwa_pkg::CMD_POP_BACK) begin
         if (n == 0) r.status = dwa_pkg::STS_EMPTY;
         else begin
            if (rq.command == dwa_pkg::CMD_POP_FRONT) begin
               if (fr_depth != 0) fr_depth--; else bk_depth--;
            end else begin
               if (bk_depth != 0) bk_depth--; else fr_depth--;
            end
            model_rebalance();
         end
      end
      n = fr_depth + bk_depth;
      if (n != 0) begin
         r.front_value = (fr_depth != 0) ? fr_val[fr_depth-1] : bk_val[bk_depth-1];
         r.back_value  = (bk_depth != 0) ? bk_val[bk_depth-1] : fr_val[fr_depth-1];
         if (fr_depth != 0 && bk_depth != 0)
            r.aggregate = combine(fr_pre[fr_depth-1], bk_pre[bk_depth-1]);
         else
            r.aggregate = (fr_depth != 0) ? fr_pre[fr_depth-1] : bk_pre[bk_depth-1];
      end
      r.count = dwa_pkg::CNT_W'(n);
      expected_rsps.insert(expected_rsps.size(), r);
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("ERROR %0t: %s got %h expected %h", $time, what, got, want);
      mismatches++;
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0)
            report_mismatch("unexpected result, count", 32'(rsp_data.count), 32'h0);
         else begin
            dwa_pkg::rsp_type w;
            w = expected_rsps[0];
            expected_rsps.delete(0);
            if (rsp_data.front_value !== w.front_value)
               report_mismatch("front_value", rsp_data.front_value, w.front_value);
            if (rsp_data.back_value !== w.back_value)
               report_mismatch("back_value", rsp_data.back_value, w.back_value);
            if (rsp_data.aggregate !== w.aggregate)
               report_mismatch("aggregate", rsp_data.aggregate, w.aggregate);
            if (rsp_data.count !== w.count)
               report_mismatch("count", 32'(rsp_data.count), 32'(w.count));
            if (rsp_data.status !== w.status)
               report_mismatch("status", 32'(rsp_data.status), 32'(w.status));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // one command transaction; start stays high when the next one follows
   task automatic send_command(logic [2:0] cmd, logic [DW-1:0] v);
      dwa_pkg::req_type rq;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      rq.command = cmd;
      rq.value   = v;
      start    <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_deque(rq);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_op(logic [2:0] op);
      drain_results();
      csr_valid <= 1'b1;
      csr_data  <= op;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      mdl_op = op;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_random(int pct_push);
      logic [2:0] cmd;
      int r;
      r = $urandom_range(99);
      if (r < pct_push)
         cmd = $urandom_range(1) ? dwa_pkg::CMD_PUSH_BACK : dwa_pkg::CMD_PUSH_FRONT;
      else if (r < 95)
         cmd = $urandom_range(1) ? dwa_pkg::CMD_POP_BACK : dwa_pkg::CMD_POP_FRONT;
      else
         cmd = 3'($urandom_range(7, 4));
      send_command(cmd, $urandom());
   endtask

   task automatic test_directed();
      idle_pct = 0;
      send_command(dwa_pkg::CMD_POP_FRONT, 32'h0);
      send_command(dwa_pkg::CMD_POP_BACK, 32'hFFFF_FFFF);
      send_command(dwa_pkg::CMD_PUSH_FRONT, 32'hFFFF_FFFF);
      send_command(dwa_pkg::CMD_PUSH_BACK, 32'h0);
      send_command(dwa_pkg::CMD_PUSH_BACK, 32'h8000_0001);
      send_command(dwa_pkg::CMD_PUSH_FRONT, 32'h7FFF_FFFE);
      send_command(dwa_pkg::CMD_QUERY, 32'h1234_5678);
      send_command(3'd5, 32'h0);
      send_command(3'd7, 32'hFFFF_FFFF);
      send_command(dwa_pkg::CMD_POP_FRONT, 32'h0);
      send_command(dwa_pkg::CMD_POP_BACK, 32'h0);
      send_command(dwa_pkg::CMD_POP_BACK, 32'h0);
      send_command(dwa_pkg::CMD_POP_FRONT, 32'h0);
      send_command(dwa_pkg::CMD_POP_FRONT, 32'h0);
   endtask

   // fill to capacity, hit the full case, then empty out
   task automatic test_full_and_empty(logic [2:0] op);
      write_op(op);
      for (int i = 0; i < CAP; i++)
         send_command($urandom_range(1) ? dwa_pkg::CMD_PUSH_BACK : dwa_pkg::CMD_PUSH_FRONT,
                      $urandom());
      send_command(dwa_pkg::CMD_PUSH_FRONT, 32'hFFFF_FFFF);
      send_command(dwa_pkg::CMD_PUSH_BACK, 32'h0);
      for (int i = 0; i <= CAP; i++)
         send_command($urandom_range(1) ? dwa_pkg::CMD_POP_BACK : dwa_pkg::CMD_POP_FRONT,
                      32'h0);
   endtask

   // change the operation while entries are held
   task automatic test_live_op_change();
      write_op(dwa_pkg::OP_SUM);
      repeat (10) send_random(80);
      write_op(dwa_pkg::OP_MAX);
      repeat (10) send_random(60);
      write_op(3'd7);
      repeat (10) send_random(50);
      write_op(3'd6);
      repeat (10) send_random(50);
   endtask

   task automatic test_random_phase(logic [2:0] op, int pct_idle, int items);
      write_op(op);
      idle_pct = pct_idle;
      for (int i = 0; i < items; i++) begin
         send_random((i % 200 < 100) ? 65 : 35);
         if (i == items / 2) drain_results();
      end
   endtask

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      csr_valid   = 1'b0;
      csr_data    = dwa_pkg::OP_SUM;
      mismatches  = 0;
      cycle_count = 0;
      idle_pct    = 0;
      mdl_op      = dwa_pkg::OP_SUM;
      fr_depth    = 0;
      bk_depth    = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_full_and_empty(dwa_pkg::OP_MIN);
      test_full_and_empty(dwa_pkg::OP_XOR);
      test_live_op_change();
      test_random_phase(dwa_pkg::OP_SUM, 0, 190);
      test_random_phase(dwa_pkg::OP_MIN, 68, 190);
      test_random_phase(dwa_pkg::OP_MAX, 29, 190);
      test_random_phase(dwa_pkg::OP_AND, 0, 190);
      test_random_phase(dwa_pkg::OP_OR, 68, 190);
      test_random_phase(dwa_pkg::OP_XOR, 0, 190);
      drain_results();
      repeat (20) @(posedge clock);

      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
